// ===== src/smr_pkg.sv =====
// Shared types and constants for the spiral matrix reorder block.
package smr_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 4;

  // Side length after reset
  localparam logic [CFG_W-1:0] MATRIX_DIM_RESET = 4'd8;

  typedef enum logic {
    SMR_LOAD,
    SMR_EMIT
  } smr_state_e;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } smr_dir_e;

  // Control from the sequencer owner to the spiral address generator
  typedef struct packed {
    logic start;
    logic step;
  } smr_gen_ctrl_t;

  // Status back from the spiral address generator
  typedef struct packed {
    logic last;
  } smr_gen_stat_t;

endpackage

// ===== src/smr_if.sv =====
// Stream interfaces for matrix elements in and spiral results out.
interface smr_elem_if;
  logic                                valid;
  logic                                ready;
  logic signed [smr_pkg::VALUE_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface smr_spiral_if;
  logic                                valid;
  logic                                ready;
  logic signed [smr_pkg::VALUE_W-1:0] spiral_value;
  logic                                spiral_last;

  modport source (output valid, output spiral_value, output spiral_last, input ready);
  modport sink   (input valid, input spiral_value, input spiral_last, output ready);
endinterface

// ===== src/smr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smr_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/smr_spiral_gen.sv =====
// Spiral walk sequencer: produces store addresses in clockwise ring order.
module smr_spiral_gen #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned SIDE_W  = $clog2(MAX_DIM + 1),
  parameter int unsigned CNT_W   = $clog2(MAX_DIM * MAX_DIM + 1),
  parameter int unsigned ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smr_pkg::smr_gen_ctrl_t ctrl_i,
  input  logic [SIDE_W-1:0]      side_i,
  input  logic [CNT_W-1:0]       total_i,
  output logic [ADDR_W-1:0]      addr_o,
  output smr_pkg::smr_gen_stat_t stat_o
);

  localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  smr_pkg::smr_dir_e dir_q, dir_d;
  logic [CW-1:0]     row_q, row_d, col_q, col_d;
  logic [CW-1:0]     top_q, top_d, bot_q, bot_d, lft_q, lft_d, rgt_q, rgt_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [ADDR_W-1:0] side_step;

  assign side_step = ADDR_W'(side_i);

  // Next position: keep going inside the ring, else turn and shrink the wall
  always_comb begin
    dir_d    = dir_q;
    row_d    = row_q;
    col_d    = col_q;
    top_d    = top_q;
    bot_d    = bot_q;
    lft_d    = lft_q;
    rgt_d    = rgt_q;
    addr_d   = addr_q;
    remain_d = remain_q;
    if (ctrl_i.start) begin
      dir_d    = smr_pkg::DIR_RIGHT;
      row_d    = '0;
      col_d    = '0;
      top_d    = '0;
      lft_d    = '0;
      bot_d    = CW'(side_i - 1'b1);
      rgt_d    = CW'(side_i - 1'b1);
      addr_d   = '0;
      remain_d = total_i;
    end else if (ctrl_i.step) begin
      remain_d = CNT_W'(remain_q - 1'b1);
      case (dir_q)
        smr_pkg::DIR_RIGHT: begin
          if (col_q < rgt_q) begin
            col_d  = CW'(col_q + 1'b1);
            addr_d = ADDR_W'(addr_q + 1'b1);
          end else begin
            top_d  = CW'(top_q + 1'b1);
            dir_d  = smr_pkg::DIR_DOWN;
            row_d  = CW'(row_q + 1'b1);
            addr_d = ADDR_W'(addr_q + side_step);
          end
        end
        smr_pkg::DIR_DOWN: begin
          if (row_q < bot_q) begin
            row_d  = CW'(row_q + 1'b1);
            addr_d = ADDR_W'(addr_q + side_step);
          end else begin
            rgt_d  = CW'(rgt_q - 1'b1);
            dir_d  = smr_pkg::DIR_LEFT;
            col_d  = CW'(col_q - 1'b1);
            addr_d = ADDR_W'(addr_q - 1'b1);
          end
        end
        smr_pkg::DIR_LEFT: begin
          if (col_q > lft_q) begin
            col_d  = CW'(col_q - 1'b1);
            addr_d = ADDR_W'(addr_q - 1'b1);
          end else begin
            bot_d  = CW'(bot_q - 1'b1);
            dir_d  = smr_pkg::DIR_UP;
            row_d  = CW'(row_q - 1'b1);
            addr_d = ADDR_W'(addr_q - side_step);
          end
        end
        smr_pkg::DIR_UP: begin
          if (row_q > top_q) begin
            row_d  = CW'(row_q - 1'b1);
            addr_d = ADDR_W'(addr_q - side_step);
          end else begin
            lft_d  = CW'(lft_q + 1'b1);
            dir_d  = smr_pkg::DIR_RIGHT;
            col_d  = CW'(col_q + 1'b1);
            addr_d = ADDR_W'(addr_q + 1'b1);
          end
        end
        default: begin
          dir_d = smr_pkg::DIR_RIGHT;
        end
      endcase
    end
  end

  // Walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= smr_pkg::DIR_RIGHT;
      remain_q <= '0;
    end else begin
      dir_q    <= dir_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    top_q  <= top_d;
    bot_q  <= bot_d;
    lft_q  <= lft_d;
    rgt_q  <= rgt_d;
    addr_q <= addr_d;
  end

  assign addr_o      = addr_q;
  assign stat_o.last = (remain_q == CNT_W'(1));

endmodule

// ===== src/spiral_matrix_reorder.sv =====
// Top level of the spiral matrix reorder block: load sequencer, store and output stage.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------------
//  in_if    | in  | valid/ready  | element_value (s32)
//  out_if   | out | valid/ready  | spiral_value (s32), spiral_last
//  cfg      | in  | cfg_we_i     | cfg_wdata_i = matrix_dim (u4)
//
// Loading writes D*D elements, one per valid cycle, through the store's write port.
// After the last element, D*D results stream at one per cycle while out_if is ready,
// set by the single read port; ready stays low while the spiral is read out.
// A stall on out_if holds the registered read data and pauses the address walk.
// Reset clears the load count, side length (8) and sequencer; store contents are not reset.
module spiral_matrix_reorder #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [smr_pkg::CFG_W-1:0]    cfg_wdata_i,
  smr_elem_if.sink                     in_if,
  smr_spiral_if.source                 out_if
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SIDE_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam logic [smr_pkg::CFG_W-1:0] MaxDimCfg = smr_pkg::CFG_W'(MAX_DIM);

  smr_pkg::smr_state_e    state_q, state_d;
  logic [SIDE_W-1:0]      side_q;
  logic [SIDE_W-1:0]      side_cfg;
  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       total;
  logic                   rd_pend_q;
  logic                   last_q;
  logic                   in_beat, out_beat, load_done, issue;
  logic [ADDR_W-1:0]      rd_addr;
  logic [smr_pkg::VALUE_W-1:0] rd_data;
  smr_pkg::smr_gen_ctrl_t gen_ctrl;
  smr_pkg::smr_gen_stat_t gen_stat;

  // Clamp the written side length into 1..MAX_DIM
  always_comb begin
    if (cfg_wdata_i == '0) begin
      side_cfg = SIDE_W'(1);
    end else if (cfg_wdata_i > MaxDimCfg) begin
      side_cfg = SIDE_W'(MAX_DIM);
    end else begin
      side_cfg = SIDE_W'(cfg_wdata_i);
    end
  end

  assign total     = CNT_W'(CNT_W'(side_q) * CNT_W'(side_q));
  assign in_beat   = in_if.valid && in_if.ready;
  assign out_beat  = out_if.valid && out_if.ready;
  assign load_done = in_beat && (count_q == CNT_W'(total - 1'b1));
  assign issue     = (state_q == smr_pkg::SMR_EMIT) && (!rd_pend_q || out_if.ready);

  assign gen_ctrl.start = load_done;
  assign gen_ctrl.step  = issue;

  // Next state: load until the matrix is full, then read out the spiral
  always_comb begin
    state_d = state_q;
    case (state_q)
      smr_pkg::SMR_LOAD: begin
        if (load_done) begin
          state_d = smr_pkg::SMR_EMIT;
        end
      end
      smr_pkg::SMR_EMIT: begin
        if (issue && gen_stat.last) begin
          state_d = smr_pkg::SMR_LOAD;
        end
      end
      default: begin
        state_d = smr_pkg::SMR_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smr_pkg::SMR_LOAD;
      side_q    <= SIDE_W'((smr_pkg::MATRIX_DIM_RESET > MaxDimCfg) ?
                           MaxDimCfg : smr_pkg::MATRIX_DIM_RESET);
      count_q   <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Drop a partial load on a register write
      if (cfg_we_i) begin
        side_q  <= side_cfg;
        count_q <= '0;
      end else if (in_beat) begin
        count_q <= load_done ? '0 : CNT_W'(count_q + 1'b1);
      end
      if (issue) begin
        rd_pend_q <= 1'b1;
      end else if (out_beat) begin
        rd_pend_q <= 1'b0;
      end
    end
  end

  // Hold the last flag alongside the read data
  always_ff @(posedge clk_i) begin
    if (issue) begin
      last_q <= gen_stat.last;
    end
  end

  smr_spiral_gen #(
    .MAX_DIM (MAX_DIM),
    .SIDE_W  (SIDE_W),
    .CNT_W   (CNT_W),
    .ADDR_W  (ADDR_W)
  ) u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .side_i  (side_q),
    .total_i (total),
    .addr_o  (rd_addr),
    .stat_o  (gen_stat)
  );

  smr_ram #(
    .WIDTH  (smr_pkg::VALUE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_beat),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (in_if.element_value),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign in_if.ready         = (state_q == smr_pkg::SMR_LOAD);
  assign out_if.valid        = rd_pend_q;
  assign out_if.spiral_value = rd_data;
  assign out_if.spiral_last  = last_q;

endmodule

// ===== src/smr_checker.sv =====
// Port-level checker for the spiral matrix reorder block, with its bind.
module smr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_last_i,
  input logic [smr_pkg::VALUE_W-1:0] out_value_i
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_last_i))
    else $error("stalled result beat changed");

  // No element is taken while a spiral run is still being read out
  a_no_load_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a spiral run");

  // Loading is open again when a fresh final beat is shown
  a_load_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i && !$past(out_valid_i && !out_ready_i) |-> in_ready_i)
    else $error("input not ready after final result");

  // Ready only falls when a load completes, so no mid-run result is pending when it does
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> !(out_valid_i && !out_last_i))
    else $error("run started with a mid-run result pending");

endmodule

bind spiral_matrix_reorder smr_checker u_smr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_last_i  (out_if.spiral_last),
  .out_value_i (out_if.spiral_value)
);
